FILE: hdl/sal_pkg.sv
package sal_pkg;

    // sizing
    localparam int SOURCE_SLOTS = 256;
    localparam int MAX_SIDE     = 4096;
    localparam int SLOT_W       = $clog2(SOURCE_SLOTS);
    localparam int SID_W        = 8;
    localparam int SID_EXT_W    = (SLOT_W > SID_W) ? SLOT_W : SID_W;
    localparam int SIDE_W       = 13;
    localparam int CNT_W        = 9;
    localparam int AREA_W       = 25;
    localparam int ACT_W        = 3;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 96;
    localparam int CFG_IDX_W    = 1;

    localparam logic [SIDE_W-1:0] ATLAS_RESET = 13'd1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC  = 3'd0,
        ACT_FREE   = 3'd1,
        ACT_LOOKUP = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_STATS  = 3'd4
    } t_action;

    typedef struct packed {
        logic [SIDE_W-1:0] h;
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] y;
        logic [SIDE_W-1:0] x;
    } t_rect;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic place;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

    // atlas side clamped to the largest supported side
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (32'(v) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: hdl/shelf_atlas_allocator.sv
// shelf atlas allocator: rectangles placed left to right on horizontal shelves
// sequence: the request is registered on accept, then fetch, place and emit run
//   around the single-port region table read and write-back; emit waits
//   for room in the output register; new requests are taken only in idle
// reset: i_rst_n synchronous active low; present flags, cursor and counts clear,
//   atlas size returns to 1024 x 1024, the region table and in-use marks are kept
module shelf_atlas_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration write port: index 0 atlas_width, index 1 atlas_height
    input  logic                                i_cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sal_pkg::SIDE_W-1:0]          i_cfg_wdata,

    // request items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // action[2:0], slot_id[10:3], rect_width[23:11], rect_height[36:24], zero pad
    input  logic [sal_pkg::IN_TDATA_W-1:0]      s_axis_tdata,

    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[0], region_x[13:1], region_y[26:14], region_width[39:27],
    // region_height[52:40], live_slots[61:53], live_area[86:62],
    // alloc_total[95:87]
    output logic [sal_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    sal_pkg::t_cmd  cmd;
    sal_pkg::t_stat stat;

    // sequencer: idle -> fetch (table data back) -> place -> emit
    sal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // region table, flags, cursor, counters and the output register
    sal_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

FILE: hdl/sal_ctrl.sv
module sal_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  sal_pkg::t_stat i_stat,
    output sal_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_PLACE,
        S_EMIT
    } t_state;

    t_state r_state;

    always_comb begin
        o_s_tready  = (r_state == S_IDLE);
        o_cmd.load  = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.fetch = (r_state == S_FETCH);
        o_cmd.place = (r_state == S_PLACE);
        o_cmd.emit  = (r_state == S_EMIT) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_PLACE;
                S_PLACE: r_state <= S_EMIT;
                S_EMIT: begin
                    // wait for room in the output register
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/sal_datapath.sv
module sal_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sal_pkg::t_cmd                       i_cmd,
    output sal_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sal_pkg::SIDE_W-1:0]          i_cfg_wdata,
    input  logic [sal_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [sal_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int SW = sal_pkg::SIDE_W;

    // region table and in-use marks, no reset, contents only used for present slots
    sal_pkg::t_rect r_table [sal_pkg::SOURCE_SLOTS];
    logic           r_in_use [sal_pkg::SOURCE_SLOTS];
    logic [sal_pkg::SOURCE_SLOTS-1:0] r_present;

    // atlas size, kept already clamped
    logic [SW-1:0] r_aw, r_ah;

    // allocation cursor and counters
    logic [SW-1:0]                 r_cx, r_cy, r_sh;
    logic [sal_pkg::CNT_W-1:0]     r_cnt, r_total;
    logic [sal_pkg::AREA_W-1:0]    r_area;

    // request registers
    sal_pkg::t_action              r_act;
    logic [sal_pkg::SLOT_W-1:0]    r_idx;
    logic                          r_sid_ok;
    logic [SW-1:0]                 r_w, r_h;
    sal_pkg::t_rect                r_rd;

    // step results
    logic                          r_pres, r_used, r_fit1;
    logic [SW-1:0]                 r_ny;
    logic [sal_pkg::AREA_W-1:0]    r_old_prod, r_new_prod;
    logic                          r_placed, r_hit, r_status;
    logic [SW-1:0]                 r_px, r_py;

    // output register
    logic                          r_out_valid;
    logic [sal_pkg::OUT_TDATA_W-1:0] r_out;

    // input unpacking
    logic [sal_pkg::ACT_W-1:0]     in_act;
    logic [sal_pkg::SID_W-1:0]     in_sid;
    logic [sal_pkg::SID_EXT_W-1:0] in_sid_ext;
    logic [SW-1:0]                 in_w, in_h;

    assign in_act     = i_s_tdata[2:0];
    assign in_sid     = i_s_tdata[10:3];
    assign in_w       = i_s_tdata[23:11];
    assign in_h       = i_s_tdata[36:24];
    assign in_sid_ext = sal_pkg::SID_EXT_W'(in_sid);

    // fit test on the current shelf and the next shelf origin
    logic [SW:0] sum_x, sum_y, sum_ny, ny_h;
    logic        fit1, fit2;
    logic [SW-1:0] ny_sat;

    assign sum_x  = {1'b0, r_cx} + {1'b0, r_w};
    assign sum_y  = {1'b0, r_cy} + {1'b0, r_h};
    assign fit1   = (sum_x <= {1'b0, r_aw}) && (sum_y <= {1'b0, r_ah});
    assign sum_ny = {1'b0, r_cy} + {1'b0, r_sh};
    assign ny_sat = sum_ny[SW] ? {SW{1'b1}} : sum_ny[SW-1:0];

    assign ny_h   = {1'b0, r_ny} + {1'b0, r_h};
    assign fit2   = (ny_h <= {1'b0, r_ah}) && (r_w <= r_aw);

    // place step decisions
    logic alloc_go, placed, free_go, drop_old, is_clear;
    logic [sal_pkg::CNT_W-1:0] n_cnt;
    logic n_status, n_hit;

    always_comb begin
        alloc_go = (r_act == sal_pkg::ACT_ALLOC) && r_sid_ok;
        placed   = alloc_go && (r_fit1 || fit2);
        free_go  = (r_act == sal_pkg::ACT_FREE) && r_sid_ok && r_pres;
        drop_old = r_pres && r_used && (placed || free_go);
        is_clear = (r_act == sal_pkg::ACT_CLEAR);
        n_cnt    = r_cnt - sal_pkg::CNT_W'(drop_old) + sal_pkg::CNT_W'(placed);
        n_hit    = (r_act == sal_pkg::ACT_LOOKUP) && r_sid_ok && r_pres && r_used;
        case (r_act)
            sal_pkg::ACT_ALLOC:  n_status = !placed;
            sal_pkg::ACT_FREE:   n_status = !free_go;
            sal_pkg::ACT_LOOKUP: n_status = !n_hit;
            sal_pkg::ACT_CLEAR:  n_status = 1'b0;
            sal_pkg::ACT_STATS:  n_status = 1'b0;
            default:             n_status = 1'b1;
        endcase
    end

    // table memory: read on accept, write on a successful placement
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= r_table[in_sid_ext[sal_pkg::SLOT_W-1:0]];
        end
        if (i_cmd.place && placed) begin
            r_table[r_idx] <= '{h: r_h, w: r_w, y: (r_fit1 ? r_cy : r_ny),
                                x: (r_fit1 ? r_cx : '0)};
        end
    end

    // in-use marks: set on placement, cleared on free
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_used <= r_in_use[r_idx];
        end
        if (i_cmd.place && placed) begin
            r_in_use[r_idx] <= 1'b1;
        end else if (i_cmd.place && free_go) begin
            r_in_use[r_idx] <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= sal_pkg::t_action'(in_act);
            r_idx    <= in_sid_ext[sal_pkg::SLOT_W-1:0];
            r_sid_ok <= (32'(in_sid_ext) < sal_pkg::SOURCE_SLOTS);
            r_w      <= in_w;
            r_h      <= in_h;
        end
        if (i_cmd.fetch) begin
            r_pres     <= r_present[r_idx];
            r_fit1     <= fit1;
            r_ny       <= ny_sat;
            r_old_prod <= {{(sal_pkg::AREA_W-SW){1'b0}}, r_rd.w} *
                          {{(sal_pkg::AREA_W-SW){1'b0}}, r_rd.h};
        end
        if (i_cmd.place) begin
            r_new_prod <= {{(sal_pkg::AREA_W-SW){1'b0}}, r_w} *
                          {{(sal_pkg::AREA_W-SW){1'b0}}, r_h};
            r_placed   <= placed;
            r_hit      <= n_hit;
            r_status   <= n_status;
            r_px       <= r_fit1 ? r_cx : '0;
            r_py       <= r_fit1 ? r_cy : r_ny;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw        <= sal_pkg::eff_side(sal_pkg::ATLAS_RESET);
            r_ah        <= sal_pkg::eff_side(sal_pkg::ATLAS_RESET);
            r_present   <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_sh        <= '0;
            r_cnt       <= '0;
            r_total     <= '0;
            r_area      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sal_pkg::CFG_ATLAS_WIDTH:  r_aw <= sal_pkg::eff_side(i_cfg_wdata);
                    sal_pkg::CFG_ATLAS_HEIGHT: r_ah <= sal_pkg::eff_side(i_cfg_wdata);
                    default: ;
                endcase
            end

            if (i_cmd.place) begin
                if (is_clear) begin
                    r_present <= '0;
                    r_cx      <= '0;
                    r_cy      <= '0;
                    r_sh      <= '0;
                    r_cnt     <= '0;
                    r_total   <= '0;
                    r_area    <= '0;
                end else begin
                    if (alloc_go) begin
                        if (r_fit1) begin
                            r_cx <= sum_x[SW-1:0];
                            if (r_h > r_sh) begin
                                r_sh <= r_h;
                            end
                        end else begin
                            // new shelf opens even when the item then fails
                            r_cy <= r_ny;
                            r_cx <= fit2 ? r_w : '0;
                            r_sh <= fit2 ? r_h : '0;
                        end
                    end
                    if (placed) begin
                        r_present[r_idx] <= 1'b1;
                        if (!r_pres) begin
                            r_total <= r_total + sal_pkg::CNT_W'(1);
                        end
                    end
                    r_cnt  <= n_cnt;
                    r_area <= r_area - (drop_old ? r_old_prod : '0);
                end
            end

            if (i_cmd.emit) begin
                r_area      <= r_area + (r_placed ? r_new_prod : '0);
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result packing
    logic [SW-1:0] o_x, o_y, o_w, o_h;
    logic [sal_pkg::AREA_W-1:0] area_sum;

    always_comb begin
        o_x = '0;
        o_y = '0;
        o_w = '0;
        o_h = '0;
        if (r_placed) begin
            o_x = r_px;
            o_y = r_py;
            o_w = r_w;
            o_h = r_h;
        end else if (r_hit) begin
            o_x = r_rd.x;
            o_y = r_rd.y;
            o_w = r_rd.w;
            o_h = r_rd.h;
        end
        area_sum = r_area + (r_placed ? r_new_prod : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= {r_total, area_sum, r_cnt, o_h, o_w, o_y, o_x, r_status};
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out;

endmodule
